// ===== design/ffha_pkg.sv =====
// Shared types and codes of the first-fit heap allocator.
package ffha_pkg;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_SIZE = 3'd1;
  localparam logic [2:0] ST_NO_MEM   = 3'd2;
  localparam logic [2:0] ST_UNKNOWN  = 3'd3;
  localparam logic [2:0] ST_DOUBLE   = 3'd4;

  typedef struct packed {
    logic        command;
    logic [31:0] request_size;
    logic [15:0] address;
  } ffha_in_t;

  typedef struct packed {
    logic [15:0] address_out;
    logic [2:0]  status;
    logic [4:0]  pages_in_use;
  } ffha_out_t;

endpackage

// ===== design/ffha_ram.sv =====
// Block table memory: one write port, one registered read port.
module ffha_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 18
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== design/first_fit_heap_allocator.sv =====
// First-fit heap allocator: top level with block table sequencer.
//
// Usage: a command is transferred at a rising edge with start high and busy
// low. in_data carries command (0 allocate, 1 free), request_size and address.
// busy stays high until the result has been shown. The result appears on
// out_data for exactly one cycle with out_valid high; the receiver cannot stall
// it and must take it in that cycle.
// cfg_we writes page_limit from cfg_wdata at any edge out of reset; it is meant to change
// only while the block is idle.
// Sequencing: each table entry visited is read through the single registered
// read port of the block table. An allocate scans up to the first fit, grows
// one page per cycle when nothing fits, and a split moves the entries above
// the fit up by one. A free scans to the block, then each coalesce moves the
// entries above down by one. The worst case is a free that merges with both
// neighbours near the start of a full table; a free of address 0 or an
// allocate of a bad size goes straight to the result.
// Reset: a synchronous active-low reset sets one free block of one page and a
// page limit of 16; the state after reset, S_INIT, writes the first table
// entry, with busy high.
module first_fit_heap_allocator
  import ffha_pkg::*;
#(
  parameter int PAGE_BYTES   = 4096,
  parameter int ALIGN_BYTES  = 8,
  parameter int HEADER_BYTES = 16,
  parameter int MAX_BLOCKS   = 64,
  parameter int MAX_PAGES    = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  ffha_in_t  in_data,
  output logic      out_valid,
  output ffha_out_t out_data,
  input  logic      cfg_we,
  input  logic [4:0] cfg_wdata
);

  localparam int SW = $clog2(MAX_PAGES * PAGE_BYTES + 1);
  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam logic [SW-1:0] HDR   = SW'(HEADER_BYTES);
  localparam logic [SW-1:0] PAGE  = SW'(PAGE_BYTES);
  localparam logic [SW-1:0] FRESH = SW'(PAGE_BYTES - HEADER_BYTES);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_BLOCKS);
  localparam logic [4:0]    PG_MAX  = 5'(MAX_PAGES);
  localparam logic [32:0]   AL_M1   = 33'(ALIGN_BYTES - 1);

  localparam logic [3:0] S_INIT     = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_SCAN_RD  = 4'd2;
  localparam logic [3:0] S_SCAN_CHK = 4'd3;
  localparam logic [3:0] S_GROW     = 4'd4;
  localparam logic [3:0] S_FIT      = 4'd5;
  localparam logic [3:0] S_SU_RD    = 4'd6;
  localparam logic [3:0] S_SU_WR    = 4'd7;
  localparam logic [3:0] S_SPL_A    = 4'd8;
  localparam logic [3:0] S_SPL_B    = 4'd9;
  localparam logic [3:0] S_F_MARK   = 4'd10;
  localparam logic [3:0] S_NX_CHK   = 4'd11;
  localparam logic [3:0] S_SD_RD    = 4'd12;
  localparam logic [3:0] S_SD_WR    = 4'd13;
  localparam logic [3:0] S_PV_CHK   = 4'd14;
  localparam logic [3:0] S_DONE     = 4'd15;

  logic [3:0]    state_r, state_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [IW-1:0] j_r, j_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [SW-1:0] off_r, off_nxt;
  logic          cur_free_r, cur_free_nxt;
  logic [SW-1:0] cur_size_r, cur_size_nxt;
  logic [4:0]    pages_r, pages_nxt;
  logic [4:0]    limit_r;
  logic          cmd_r, cmd_nxt;
  logic [31:0]   round_r, round_nxt;
  logic [15:0]   target_r, target_nxt;
  logic [2:0]    status_r, status_nxt;
  logic [15:0]   addr_r, addr_nxt;
  logic          phase_r, phase_nxt;

  logic          mem_we;
  logic [IW-1:0] mem_waddr, mem_raddr;
  logic [SW:0]   mem_wdata, mem_rdata;

  logic          rd_free;
  logic [SW-1:0] rd_size;
  logic [CW-1:0] idx_ext, j_ext;
  logic [32:0]   rnd_sum, rnd_val;
  logic          rd_fits, cur_fits;
  logic [SW-1:0] rest;

  ffha_ram #(.DEPTH(MAX_BLOCKS), .WIDTH(SW + 1)) u_table (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign rd_free  = mem_rdata[SW];
  assign rd_size  = mem_rdata[SW-1:0];
  assign idx_ext  = CW'(idx_r);
  assign j_ext    = CW'(j_r);
  assign rnd_sum  = {1'b0, in_data.request_size} + AL_M1;
  assign rnd_val  = rnd_sum & ~AL_M1;
  assign rd_fits  = rd_free && (33'(rd_size) >= {1'b0, round_r});
  assign cur_fits = cur_free_r && (33'(cur_size_r) >= {1'b0, round_r});
  assign rest     = cur_size_r - round_r[SW-1:0];

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    j_nxt        = j_r;
    count_nxt    = count_r;
    off_nxt      = off_r;
    cur_free_nxt = cur_free_r;
    cur_size_nxt = cur_size_r;
    pages_nxt    = pages_r;
    cmd_nxt      = cmd_r;
    round_nxt    = round_r;
    target_nxt   = target_r;
    status_nxt   = status_r;
    addr_nxt     = addr_r;
    phase_nxt    = phase_r;
    mem_we       = 1'b0;
    mem_waddr    = idx_r;
    mem_wdata    = '0;
    mem_raddr    = idx_r;
    case (state_r)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = {1'b1, FRESH};
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd_nxt    = in_data.command;
          target_nxt = in_data.address;
          round_nxt  = rnd_val[31:0];
          idx_nxt    = '0;
          off_nxt    = '0;
          status_nxt = ST_OK;
          addr_nxt   = '0;
          if (in_data.command == CMD_ALLOC) begin
            if (in_data.request_size == 32'd0 || rnd_val[32]) begin
              status_nxt = ST_BAD_SIZE;
              state_nxt  = S_DONE;
            end else begin
              state_nxt = S_SCAN_RD;
            end
          end else if (in_data.address == 16'd0) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SCAN_RD;
          end
        end
      end
      S_SCAN_RD: begin
        state_nxt = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        cur_free_nxt = rd_free;
        cur_size_nxt = rd_size;
        if (cmd_r == CMD_ALLOC) begin
          if (rd_fits) begin
            state_nxt = S_FIT;
          end else if (idx_ext + 1'b1 == count_r) begin
            state_nxt = S_GROW;
          end else begin
            off_nxt   = off_r + HDR + rd_size;
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_SCAN_RD;
          end
        end else begin
          if (off_r + HDR == SW'(target_r)) begin
            if (rd_free) begin
              status_nxt = ST_DOUBLE;
              state_nxt  = S_DONE;
            end else begin
              cur_free_nxt = 1'b1;
              state_nxt    = S_F_MARK;
            end
          end else if (idx_ext + 1'b1 == count_r) begin
            status_nxt = ST_UNKNOWN;
            state_nxt  = S_DONE;
          end else begin
            off_nxt   = off_r + HDR + rd_size;
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_SCAN_RD;
          end
        end
      end
      S_GROW: begin
        if (cur_fits) begin
          state_nxt = S_FIT;
        end else if (pages_r >= limit_r || pages_r >= PG_MAX) begin
          status_nxt = ST_NO_MEM;
          state_nxt  = S_DONE;
        end else if (cur_free_r) begin
          cur_size_nxt = cur_size_r + PAGE;
          mem_we       = 1'b1;
          mem_waddr    = idx_r;
          mem_wdata    = {1'b1, cur_size_r + PAGE};
          pages_nxt    = pages_r + 1'b1;
        end else if (count_r >= CNT_MAX) begin
          status_nxt = ST_NO_MEM;
          state_nxt  = S_DONE;
        end else begin
          off_nxt      = off_r + HDR + cur_size_r;
          idx_nxt      = count_r[IW-1:0];
          mem_we       = 1'b1;
          mem_waddr    = count_r[IW-1:0];
          mem_wdata    = {1'b1, FRESH};
          cur_free_nxt = 1'b1;
          cur_size_nxt = FRESH;
          count_nxt    = count_r + 1'b1;
          pages_nxt    = pages_r + 1'b1;
        end
      end
      S_FIT: begin
        addr_nxt   = 16'(off_r + HDR);
        status_nxt = ST_OK;
        if (rest > HDR && count_r < CNT_MAX) begin
          j_nxt = IW'(count_r - 1'b1);
          if (count_r - 1'b1 > idx_ext) begin
            state_nxt = S_SU_RD;
          end else begin
            state_nxt = S_SPL_A;
          end
        end else begin
          mem_we    = 1'b1;
          mem_waddr = idx_r;
          mem_wdata = {1'b0, cur_size_r};
          state_nxt = S_DONE;
        end
      end
      S_SU_RD: begin
        mem_raddr = j_r;
        state_nxt = S_SU_WR;
      end
      S_SU_WR: begin
        mem_we    = 1'b1;
        mem_waddr = j_r + 1'b1;
        mem_wdata = mem_rdata;
        if (j_r == idx_r + 1'b1) begin
          state_nxt = S_SPL_A;
        end else begin
          j_nxt     = j_r - 1'b1;
          state_nxt = S_SU_RD;
        end
      end
      S_SPL_A: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r + 1'b1;
        mem_wdata = {1'b1, rest - HDR};
        state_nxt = S_SPL_B;
      end
      S_SPL_B: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        mem_wdata = {1'b0, round_r[SW-1:0]};
        count_nxt = count_r + 1'b1;
        state_nxt = S_DONE;
      end
      S_F_MARK: begin
        mem_raddr = idx_r + 1'b1;
        if (idx_ext + 1'b1 < count_r) begin
          state_nxt = S_NX_CHK;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = idx_r;
          mem_wdata = {1'b1, cur_size_r};
          mem_raddr = idx_r - 1'b1;
          state_nxt = (idx_r == '0) ? S_DONE : S_PV_CHK;
        end
      end
      S_NX_CHK: begin
        if (rd_free) begin
          cur_size_nxt = cur_size_r + HDR + rd_size;
          j_nxt        = idx_r + 1'b1;
          phase_nxt    = 1'b0;
          state_nxt    = S_SD_RD;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = idx_r;
          mem_wdata = {1'b1, cur_size_r};
          mem_raddr = idx_r - 1'b1;
          state_nxt = (idx_r == '0) ? S_DONE : S_PV_CHK;
        end
      end
      S_SD_RD: begin
        mem_raddr = j_r + 1'b1;
        if (j_ext + 1'b1 < count_r) begin
          state_nxt = S_SD_WR;
        end else begin
          count_nxt = count_r - 1'b1;
          if (phase_r) begin
            state_nxt = S_DONE;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = idx_r;
            mem_wdata = {1'b1, cur_size_r};
            mem_raddr = idx_r - 1'b1;
            state_nxt = (idx_r == '0) ? S_DONE : S_PV_CHK;
          end
        end
      end
      S_SD_WR: begin
        mem_we    = 1'b1;
        mem_waddr = j_r;
        mem_wdata = mem_rdata;
        j_nxt     = j_r + 1'b1;
        state_nxt = S_SD_RD;
      end
      S_PV_CHK: begin
        if (rd_free) begin
          mem_we    = 1'b1;
          mem_waddr = idx_r - 1'b1;
          mem_wdata = {1'b1, rd_size + HDR + cur_size_r};
          j_nxt     = idx_r;
          phase_nxt = 1'b1;
          state_nxt = S_SD_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_INIT;
      idx_r      <= '0;
      j_r        <= '0;
      count_r    <= CW'(1);
      off_r      <= '0;
      cur_free_r <= 1'b0;
      cur_size_r <= '0;
      pages_r    <= 5'd1;
      limit_r    <= 5'd16;
      cmd_r      <= CMD_ALLOC;
      round_r    <= '0;
      target_r   <= '0;
      status_r   <= ST_OK;
      addr_r     <= '0;
      phase_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      idx_r      <= idx_nxt;
      j_r        <= j_nxt;
      count_r    <= count_nxt;
      off_r      <= off_nxt;
      cur_free_r <= cur_free_nxt;
      cur_size_r <= cur_size_nxt;
      pages_r    <= pages_nxt;
      cmd_r      <= cmd_nxt;
      round_r    <= round_nxt;
      target_r   <= target_nxt;
      status_r   <= status_nxt;
      addr_r     <= addr_nxt;
      phase_r    <= phase_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
    end
  end

  assign busy                  = (state_r != S_IDLE);
  assign out_valid             = (state_r == S_DONE);
  assign out_data.address_out  = addr_r;
  assign out_data.status       = status_r;
  assign out_data.pages_in_use = pages_r;

endmodule

// ===== design/ffha_checker.sv =====
// Port-level checks of the heap allocator, bound to the top level.
module ffha_props
  import ffha_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input ffha_out_t out_data
);

  a_out_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result shown while idle");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held");

  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("transfer did not raise busy");

  a_null_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ST_OK) |-> out_data.address_out == 16'd0)
    else $error("address on failed command");

  a_pages_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.pages_in_use != 5'd0) else $error("heap spans no page");

endmodule

bind first_fit_heap_allocator ffha_props u_ffha_props (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .out_valid(out_valid),
  .out_data (out_data)
);

// ===== dv/ffha_checker.sv =====
// Checker for the first-fit heap allocator: predicts each result and compares.
`timescale 1ns / 1ps
module ffha_checker
  import ffha_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  ffha_in_t  in_data,
  input  logic      out_valid,
  input  ffha_out_t out_data,
  input  logic      cfg_we,
  input  logic [4:0] cfg_wdata,
  output int        fail_count,
  output int        pending
);

  localparam int PAGE = 4096;
  localparam int ALIGN = 8;
  localparam int HDR = 16;
  localparam int NBLK = 64;
  localparam int NPAGE = 16;

  logic [16:0] blk_bytes [NBLK];
  logic        blk_avail [NBLK];
  int          blk_total;
  int          pages;
  logic [4:0]  limit;
  ffha_out_t   expected_q[$];

  assign pending = expected_q.size();

  task automatic report(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic void heap_reset();
    for (int i = 0; i < NBLK; i++) begin
      blk_bytes[i] = '0;
      blk_avail[i] = 1'b0;
    end
    blk_bytes[0] = 17'(PAGE - HDR);
    blk_avail[0] = 1'b1;
    blk_total = 1;
    pages = 1;
  endfunction

  function automatic void drop_entry(int idx);
    for (int j = idx; j < blk_total - 1; j++) begin
      blk_bytes[j] = blk_bytes[j + 1];
      blk_avail[j] = blk_avail[j + 1];
    end
    blk_total--;
  endfunction

  function automatic bit add_page();
    int last;
    last = blk_total - 1;
    if (pages >= int'(limit) || pages >= NPAGE) return 0;
    if (blk_avail[last]) begin
      blk_bytes[last] = blk_bytes[last] + 17'(PAGE);
    end else begin
      if (blk_total >= NBLK) return 0;
      blk_bytes[blk_total] = 17'(PAGE - HDR);
      blk_avail[blk_total] = 1'b1;
      blk_total++;
    end
    pages++;
    return 1;
  endfunction

  function automatic int first_fit(longint need, output int offs);
    int o;
    o = 0;
    offs = 0;
    for (int i = 0; i < blk_total; i++) begin
      if (blk_avail[i] && longint'(blk_bytes[i]) >= need) begin
        offs = o;
        return i;
      end
      o += HDR + blk_bytes[i];
    end
    return -1;
  endfunction

  function automatic ffha_out_t heap_step(ffha_in_t cmd);
    ffha_out_t r;
    longint rounded;
    int idx, offs, rest, o, i;
    bit hit;
    r = '0;
    r.status = ST_OK;
    if (cmd.command == CMD_ALLOC) begin
      rounded = ((longint'(cmd.request_size) + ALIGN - 1) / ALIGN) * ALIGN;
      if (cmd.request_size == 0 || rounded > 64'hFFFF_FFFF) begin
        r.status = ST_BAD_SIZE;
      end else begin
        idx = first_fit(rounded, offs);
        while (idx < 0) begin
          if (!add_page()) break;
          idx = first_fit(rounded, offs);
        end
        if (idx < 0) begin
          r.status = ST_NO_MEM;
        end else begin
          rest = blk_bytes[idx] - int'(rounded);
          if (rest > HDR && blk_total < NBLK) begin
            for (int j = blk_total; j > idx + 1; j--) begin
              blk_bytes[j] = blk_bytes[j - 1];
              blk_avail[j] = blk_avail[j - 1];
            end
            blk_bytes[idx + 1] = 17'(rest - HDR);
            blk_avail[idx + 1] = 1'b1;
            blk_bytes[idx] = 17'(rounded);
            blk_total++;
          end
          blk_avail[idx] = 1'b0;
          r.address_out = 16'(offs + HDR);
        end
      end
    end else if (cmd.address != 0) begin
      o = 0;
      hit = 0;
      for (i = 0; i < blk_total; i++) begin
        if (o + HDR == int'(cmd.address)) begin
          hit = 1;
          break;
        end
        o += HDR + blk_bytes[i];
      end
      if (!hit) begin
        r.status = ST_UNKNOWN;
      end else if (blk_avail[i]) begin
        r.status = ST_DOUBLE;
      end else begin
        blk_avail[i] = 1'b1;
        i = 0;
        while (i + 1 < blk_total) begin
          if (blk_avail[i] && blk_avail[i + 1]) begin
            blk_bytes[i] = blk_bytes[i] + 17'(HDR) + blk_bytes[i + 1];
            drop_entry(i + 1);
          end else begin
            i++;
          end
        end
      end
    end
    r.pages_in_use = pages[4:0];
    return r;
  endfunction

  always @(posedge clk) begin
    ffha_out_t want;
    if (!rst_n) begin
      heap_reset();
      limit <= 5'd16;
      expected_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) limit <= cfg_wdata;
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          report("unexpected transfer", 1, 0);
        end else begin
          want = expected_q.pop_front();
          if (out_data.address_out != want.address_out)
            report("address_out", out_data.address_out, want.address_out);
          if (out_data.status != want.status)
            report("status", out_data.status, want.status);
          if (out_data.pages_in_use != want.pages_in_use)
            report("pages_in_use", out_data.pages_in_use, want.pages_in_use);
        end
      end
      if (start && !busy) expected_q.push_back(heap_step(in_data));
    end
  end

endmodule

// ===== dv/tb_top.sv =====
// Top of the first-fit heap allocator testbench: stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
  import ffha_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  ffha_in_t  in_data;
  logic      out_valid;
  ffha_out_t out_data;
  logic      cfg_we;
  logic [4:0] cfg_wdata;
  int        fail_count;
  int        pending;
  logic [15:0] live_q[$];

  first_fit_heap_allocator i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  ffha_checker i_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_data.status == ST_OK && out_data.address_out != 0)
      live_q.push_back(out_data.address_out);
  end

  task automatic issue(input logic cmd, input logic [31:0] size, input logic [15:0] addr);
    @(negedge clk);
    start <= 1'b1;
    in_data <= '{command: cmd, request_size: size, address: addr};
    do @(posedge clk); while (busy);
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (450) @(negedge clk);
  endtask

  task automatic set_limit(input logic [4:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_item();
    int k, pick;
    logic [31:0] sz;
    k = $urandom_range(0, 99);
    if (k < 45) begin
      case ($urandom_range(0, 5))
        0: sz = $urandom;
        1: sz = $urandom_range(3000, 9000);
        default: sz = $urandom_range(1, 600);
      endcase
      issue(CMD_ALLOC, sz, 16'($urandom));
    end else if (k < 85 && live_q.size() != 0) begin
      pick = $urandom_range(0, live_q.size() - 1);
      issue(CMD_FREE, $urandom, live_q[pick]);
      if ($urandom_range(0, 3) != 0) live_q.delete(pick);
    end else begin
      issue(CMD_FREE, $urandom, 16'($urandom));
    end
  endtask

  initial begin
    int gap;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = 5'd16;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    issue(CMD_ALLOC, 32'd0, 16'd0);
    issue(CMD_ALLOC, 32'hFFFF_FFFF, 16'hFFFF);
    issue(CMD_ALLOC, 32'hFFFF_FFF8, 16'd0);
    issue(CMD_ALLOC, 32'd1, 16'd0);
    issue(CMD_ALLOC, 32'd4064, 16'd0);
    issue(CMD_ALLOC, 32'd5000, 16'd0);
    issue(CMD_FREE, 32'd0, 16'd0);
    issue(CMD_FREE, 32'hFFFF_FFFF, 16'hFFFF);
    issue(CMD_FREE, 32'd0, 16'd16);
    issue(CMD_FREE, 32'd0, 16'd16);
    issue(CMD_FREE, 32'd0, 16'd40);
    issue(CMD_ALLOC, 32'd70000, 16'd0);
    for (int i = 0; i < 70; i++) issue(CMD_ALLOC, 32'd24, 16'd0);
    live_q.delete();
    set_limit(5'd1);
    issue(CMD_ALLOC, 32'd60000, 16'd0);

    for (int ph = 0; ph < 5; ph++) begin
      rst_n <= rst_n;
      case (ph)
        0: set_limit(5'd31);
        1: set_limit(5'd0);
        2: set_limit(5'd4);
        3: set_limit(5'd16);
        default: set_limit(5'($urandom_range(1, 16)));
      endcase
      for (int n = 0; n < 100; n++) begin
        if ($urandom_range(0, 4) == 0) begin
          gap = $urandom_range(1, 20);
          repeat (gap) @(negedge clk);
        end
        if (n == 50) begin
          while (pending != 0) @(negedge clk);
        end
        random_item();
      end
    end

    drain();
    if (fail_count == 0)
      $display("first_fit_heap_allocator verification clean");
    else
      $display("first_fit_heap_allocator verification failed");
    $finish;
  end

  initial begin
    #8000000;
    $display("first_fit_heap_allocator verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
design/ffha_pkg.sv
design/ffha_ram.sv
design/first_fit_heap_allocator.sv
design/ffha_checker.sv
dv/ffha_checker.sv
dv/tb_top.sv
